// ----- rtl/efri_pkg.sv -----
// shared types and constants for the extended float round-to-integral block
// no dependencies
package efri_pkg;

    localparam int unsigned SIG_BITS_DEF = 64;
    localparam int unsigned EXP_BITS_DEF = 15;

    localparam int unsigned KIND_W = 3;
    localparam int unsigned MODE_W = 2;

    typedef enum logic [KIND_W-1:0] {
        K_TRUNC = 3'd0,
        K_FLOOR = 3'd1,
        K_CEIL  = 3'd2,
        K_ROUND = 3'd3,
        K_RINT  = 3'd4
    } t_kind;

    typedef enum logic [MODE_W-1:0] {
        M_NEAREST = 2'd0,
        M_DOWN    = 2'd1,
        M_UP      = 2'd2,
        M_ZERO    = 2'd3
    } t_mode;

    // one operand item as held in the input register
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [15:0]       sign_exp;
        logic [63:0]       sig;
    } t_item;

    // one result item
    typedef struct packed {
        logic [15:0] sign_exp;
        logic [63:0] sig;
    } t_result;

endpackage

// ----- rtl/efri_core.sv -----
// combinational rounding datapath: shift, round decision, increment, normalize
// depends on efri_pkg
module efri_core #(
    parameter int unsigned SIGNIFICAND_BITS = efri_pkg::SIG_BITS_DEF,
    parameter int unsigned EXPONENT_BITS    = efri_pkg::EXP_BITS_DEF
) (
    input  efri_pkg::t_item   i_item,
    input  logic [1:0]        i_mode,
    output efri_pkg::t_result o_res
);
    import efri_pkg::*;

    localparam int unsigned SB    = SIGNIFICAND_BITS;
    localparam int unsigned EB    = EXPONENT_BITS;
    localparam int unsigned BIAS  = (1 << (EB - 1)) - 1;
    localparam int unsigned SHW   = 7;
    localparam int unsigned PW    = 7;
    localparam int unsigned IW    = $clog2(SB);

    logic [EB-1:0]  e;
    logic [EB-1:0]  e_eff;
    logic           neg;
    logic [SB-1:0]  sig;
    logic           special;
    logic [EB:0]    shift_w;
    logic [SHW-1:0] shift;
    logic [IW-1:0]  half_idx;
    logic           far;
    logic [SB-1:0]  ip;
    logic [SB-1:0]  frac_mask;
    logic           inexact;
    logic           ge_half;
    logic           bump;
    logic [SB-1:0]  m;
    logic [PW-1:0]  p;
    logic [SB-1:0]  m_norm;
    logic [2:0]     op;

    assign e   = i_item.sign_exp[EB-1:0];
    assign neg = i_item.sign_exp[15];
    assign sig = i_item.sig[SB-1:0];
    assign e_eff = (e == '0) ? EB'(1) : e;

    // special-case detection and shift amount; far shift when the unbiased exponent is below zero
    always_comb begin
        special = (e == {EB{1'b1}}) || (sig == '0)
                  || ({1'b0, e_eff} >= (EB+1)'(BIAS + SB - 1));
        shift_w = (EB+1)'(BIAS + SB - 1) - {1'b0, e_eff};
        far     = (shift_w >= (EB+1)'(SB));
        shift   = far ? SHW'(SB) : shift_w[SHW-1:0];
    end

    // bit just below the integer part
    assign half_idx = IW'(shift - SHW'(1));

    // integer part and discarded-fraction flags
    always_comb begin
        if (far) begin
            ip        = '0;
            frac_mask = '1;
            inexact   = 1'b1;
            ge_half   = (shift_w == (EB+1)'(SB)) && sig[SB-1];
        end else begin
            ip        = sig >> shift;
            frac_mask = ~({SB{1'b1}} << shift);
            inexact   = (sig & frac_mask) != '0;
            ge_half   = sig[half_idx];
        end
    end

    // round decision; rint maps onto the other kinds
    always_comb begin
        op = i_item.kind;
        if (i_item.kind == K_RINT) begin
            case (t_mode'(i_mode))
                M_NEAREST: op = K_ROUND;
                M_DOWN:    op = K_FLOOR;
                M_UP:      op = K_CEIL;
                default:   op = K_TRUNC;
            endcase
        end
        case (op)
            K_FLOOR: bump = neg && inexact;
            K_CEIL:  bump = !neg && inexact;
            K_ROUND: bump = ge_half;
            default: bump = 1'b0;
        endcase
        m = ip + SB'(bump);
    end

    // leading-one position for normalization
    always_comb begin
        p = '0;
        for (int i = 0; i < SB; i++) begin
            if (m[i]) p = PW'(i);
        end
        m_norm = m << (PW'(SB - 1) - p);
    end

    // result assembly
    always_comb begin
        o_res.sign_exp = i_item.sign_exp;
        o_res.sig      = i_item.sig;
        if (!special) begin
            o_res.sig = '0;
            if (m == '0) begin
                o_res.sign_exp = {neg, 15'd0};
            end else begin
                o_res.sign_exp = {neg, 15'd0};
                o_res.sign_exp[EB-1:0] = EB'(BIAS) + EB'(p);
                o_res.sig[SB-1:0] = m_norm;
            end
        end
    end

endmodule

// ----- rtl/extended_float_round_to_integral.sv -----
// top level of the extended float round-to-integral block
// depends on efri_pkg and efri_core
//
// Rounds one 80-bit extended float per cycle to an integral value by truncate, floor,
// ceiling, round half away or rint under the configured mode. An item is held in the input
// register, passes the shift, round and normalize logic, and lands in the result register;
// a new transfer is taken every cycle while the result side keeps up. The user must write
// the rounding mode through the config channel only while the block is idle; the block
// itself does not enforce this.
module extended_float_round_to_integral #(
    parameter int unsigned SIGNIFICAND_BITS = efri_pkg::SIG_BITS_DEF,
    parameter int unsigned EXPONENT_BITS    = efri_pkg::EXP_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_data,      // [1:0] rounding_mode
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [87:0]  s_axis_tdata,    // [2:0] kind, [18:3] value_sign_exponent,
                                          // [82:19] value_significand
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata     // [15:0] result_sign_exponent,
                                          // [79:16] result_significand
);
    import efri_pkg::*;

    logic [1:0]  r_mode;
    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_result     r_out;
    t_result     core_res;
    logic        adv_in;
    logic        adv_out;

    assign o_cfg_ready = 1'b1;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NEAREST;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data[1:0];
        end
    end

    // two-stage pipeline handshake
    assign adv_out       = !r_out_valid || m_axis_tready;
    assign adv_in        = !r_in_valid || adv_out;
    assign s_axis_tready = adv_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_in)  r_in_valid  <= s_axis_tvalid;
            if (adv_out) r_out_valid <= r_in_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv_in && s_axis_tvalid) begin
            r_in.kind     <= s_axis_tdata[2:0];
            r_in.sign_exp <= s_axis_tdata[18:3];
            r_in.sig      <= s_axis_tdata[82:19];
        end
        if (adv_out && r_in_valid) begin
            r_out <= core_res;
        end
    end

    efri_core #(
        .SIGNIFICAND_BITS(SIGNIFICAND_BITS),
        .EXPONENT_BITS   (EXPONENT_BITS)
    ) u_core (
        .i_item(r_in),
        .i_mode(r_mode),
        .o_res (core_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.sig, r_out.sign_exp};

endmodule

// ----- dv/tb_extended_float_round_to_integral.sv -----
// testbench for the extended float round-to-integral block: directed and random operands
// depends on efri_pkg and extended_float_round_to_integral
module tb_extended_float_round_to_integral;
    import efri_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned EXP_MAX   = 16'h7FFF;
    localparam int          EXP_BIAS  = 16383;
    localparam int unsigned TIMEOUT   = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;

    t_mode       cur_mode;
    t_result     rounded_q[$];
    int unsigned mismatches;
    int unsigned cycles;
    int          no_stall;

    extended_float_round_to_integral uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // expected integral value for one operand under the current mode
    function automatic t_result round_integral(t_kind kind, logic [15:0] se, logic [63:0] sig);
        t_result     r;
        logic [14:0] e;
        logic        neg;
        int          k;
        int          sh;
        int          p;
        logic [63:0] ip;
        logic [63:0] m;
        logic        inexact;
        logic        ge_half;
        logic        bump;
        t_kind       eff;
        e   = se[14:0];
        neg = se[15];
        r.sign_exp = se;
        r.sig      = sig;
        if (e == EXP_MAX || sig == 64'd0) return r;
        k = int'((e == 0) ? 15'd1 : e) - EXP_BIAS;
        if (k >= 63) return r;
        sh = 63 - k;
        if (sh >= 64) begin
            ip      = 64'd0;
            inexact = 1'b1;
            ge_half = (sh == 64) && sig[63];
        end else begin
            ip      = sig >> sh;
            inexact = (sig & ((64'd1 << sh) - 64'd1)) != 64'd0;
            ge_half = sig[sh-1];
        end
        eff = kind;
        if (kind == K_RINT) begin
            case (cur_mode)
                M_NEAREST: eff = K_ROUND;
                M_DOWN:    eff = K_FLOOR;
                M_UP:      eff = K_CEIL;
                default:   eff = K_TRUNC;
            endcase
        end
        case (eff)
            K_FLOOR: bump = neg && inexact;
            K_CEIL:  bump = !neg && inexact;
            K_ROUND: bump = ge_half;
            default: bump = 1'b0;
        endcase
        m = ip + {63'd0, bump};
        if (m == 64'd0) begin
            r.sign_exp = {neg, 15'd0};
            r.sig      = 64'd0;
            return r;
        end
        p = 63;
        while (!m[p]) p--;
        r.sign_exp = {neg, 15'(EXP_BIAS + p)};
        r.sig      = m << (63 - p);
        return r;
    endfunction

    // random idling, suppressed while no_stall counts down
    function automatic bit want_idle();
        if (no_stall > 0) return 1'b0;
        return $urandom_range(99) < 37;
    endfunction

    // valid stays high after a transfer until the next idle cycle or a drain
    task automatic send_operand(logic [2:0] kind, logic [15:0] se, logic [63:0] sig);
        while (want_idle()) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, sig, se, kind};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        rounded_q.push_back(round_integral(t_kind'(kind), se, sig));
        if (no_stall > 0) no_stall--;
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (rounded_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_mode(t_mode md);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= {6'd0, md};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cur_mode = md;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // specials, extremes and ties; one operand under every kind
    task automatic test_directed();
        logic [2:0] kd;
        for (int i = 0; i < 8; i++) begin
            kd = 3'(i);
            send_operand(kd, 16'hC000, 64'hC000_0000_0000_0000);   // -3.0: exact
        end
        send_operand(K_TRUNC, 16'h7FFF, 64'hC000_0000_0000_0001);  // nan
        send_operand(K_CEIL,  16'hFFFF, 64'h8000_0000_0000_0000);  // -inf
        send_operand(K_ROUND, 16'h1234, 64'd0);                    // zero
        send_operand(K_FLOOR, 16'h403E, 64'hFFFF_FFFF_FFFF_FFFF);  // large
        send_operand(K_CEIL,  16'h0000, 64'h0000_0000_0000_0001);  // denormal
        send_operand(K_FLOOR, 16'h8000, 64'hFFFF_FFFF_FFFF_FFFF);  // neg denormal
        send_operand(K_ROUND, 16'h3FFE, 64'h8000_0000_0000_0000);  // 0.5
        send_operand(K_TRUNC, 16'hBFFD, 64'hFFFF_FFFF_FFFF_FFFF);  // neg zero result
        send_operand(K_CEIL,  16'h403D, 64'h7FFF_FFFF_FFFF_FFFF);  // unnormal
        send_operand(K_CEIL,  16'h403D, 64'hFFFF_FFFF_FFFF_FFFF);  // carry to 2^63
        send_operand(K_RINT,  16'h3FFF, 64'hC000_0000_0000_0000);  // 1.5
    endtask

    task automatic test_rint_modes();
        t_mode md;
        for (int i = 3; i >= 0; i--) begin
            md = t_mode'(i);
            write_mode(md);
            send_operand(K_RINT, 16'hC000, 64'hA000_0000_0000_0000);
            send_operand(K_RINT, 16'h4000, 64'hE000_0000_0000_0000);
        end
    endtask

    task automatic test_random(int n);
        logic [15:0] se;
        logic [63:0] sig;
        logic [2:0]  kd;
        for (int i = 0; i < n; i++) begin
            if (i % 137 == 0) begin
                write_mode(t_mode'($urandom_range(3)));
                no_stall = (i == 137) ? 60 : 0;
            end
            kd  = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
            sig = {$urandom(), $urandom()};
            se  = 16'($urandom());
            if ($urandom_range(9) < 7)
                se[14:0] = 15'(EXP_BIAS - 3 + $urandom_range(68));
            if ($urandom_range(19) == 0) se[14:0] = $urandom_range(1) ? 15'h7FFF : 15'h0;
            if ($urandom_range(29) == 0) sig = 64'd0;
            send_operand(kd, se, sig);
        end
    endtask

    // result side: random stalls and checks
    always @(negedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= !want_idle();
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rounded_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
            end else begin
                exp_r = rounded_q.pop_front();
                if (m_axis_tdata[15:0] !== exp_r.sign_exp
                        || m_axis_tdata[79:16] !== exp_r.sig) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected se %h sig %h, got se %h sig %h",
                                 exp_r.sign_exp, exp_r.sig,
                                 m_axis_tdata[15:0], m_axis_tdata[79:16]);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > TIMEOUT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cur_mode      = M_NEAREST;
        mismatches    = 0;
        cycles        = 0;
        no_stall      = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_rint_modes();
        test_random(550);
        drain();
        if (mismatches == 0 && rounded_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
